### rtl/lpfd_pkg.sv
// Shared types and constants for the length-prefixed frame deframer.
package lpfd_pkg;

  localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd10485760;
  localparam logic [2:0]  HDR_LAST_BYTE     = 3'd7;
  localparam logic [2:0]  HDR_SERVICE_BYTES = 3'd4;

  typedef enum logic [1:0] {
    PHASE_HEADER  = 2'd0,
    PHASE_PAYLOAD = 2'd1,
    PHASE_ERROR   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [31:0] service_id;
    logic [31:0] frame_length;
    logic [7:0]  payload_byte;
    logic        has_byte;
    logic        last;
    logic        status;
  } result_t;

endpackage

### rtl/lpfd_parser.sv
// Frame parser: header gathering, payload counting, sticky length error.
module lpfd_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           data_byte,
  input  logic [31:0]          max_payload,
  output logic                 res_valid,
  output lpfd_pkg::result_t    res
);

  lpfd_pkg::phase_t phase, phase_next;
  logic [2:0]  header_count, header_count_next;
  logic [31:0] held_service, held_service_next;
  logic [31:0] held_length, held_length_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic [31:0] len_full;

  assign len_full = {held_length[23:0], data_byte};

  always_comb begin
    phase_next        = phase;
    header_count_next = header_count;
    held_service_next = held_service;
    held_length_next  = held_length;
    bytes_left_next   = bytes_left;
    case (phase)
      lpfd_pkg::PHASE_HEADER: begin
        if (header_count < lpfd_pkg::HDR_SERVICE_BYTES) begin
          held_service_next = {held_service[23:0], data_byte};
        end else begin
          held_length_next = len_full;
        end
        header_count_next = header_count + 3'd1;
        if (header_count == lpfd_pkg::HDR_LAST_BYTE) begin
          if (len_full > max_payload) begin
            phase_next = lpfd_pkg::PHASE_ERROR;
          end else if (len_full != 32'd0) begin
            bytes_left_next = len_full;
            phase_next      = lpfd_pkg::PHASE_PAYLOAD;
          end
        end
      end
      lpfd_pkg::PHASE_PAYLOAD: begin
        bytes_left_next = bytes_left - 32'd1;
        if (bytes_left == 32'd1) begin
          phase_next        = lpfd_pkg::PHASE_HEADER;
          header_count_next = 3'd0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_valid        = 1'b0;
    res.service_id   = held_service;
    res.frame_length = held_length;
    res.payload_byte = 8'd0;
    res.has_byte     = 1'b0;
    res.last         = 1'b0;
    res.status       = 1'b0;
    case (phase)
      lpfd_pkg::PHASE_HEADER: begin
        if (header_count == lpfd_pkg::HDR_LAST_BYTE) begin
          res.frame_length = len_full;
          if (len_full > max_payload) begin
            res_valid  = 1'b1;
            res.status = 1'b1;
          end else if (len_full == 32'd0) begin
            res_valid = 1'b1;
            res.last  = 1'b1;
          end
        end
      end
      lpfd_pkg::PHASE_PAYLOAD: begin
        res_valid        = 1'b1;
        res.payload_byte = data_byte;
        res.has_byte     = 1'b1;
        res.last         = (bytes_left == 32'd1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= lpfd_pkg::PHASE_HEADER;
      header_count <= 3'd0;
      held_service <= 32'd0;
      held_length  <= 32'd0;
      bytes_left   <= 32'd0;
    end else if (step) begin
      phase        <= phase_next;
      header_count <= header_count_next;
      held_service <= held_service_next;
      held_length  <= held_length_next;
      bytes_left   <= bytes_left_next;
    end
  end

endmodule

### rtl/lpfd_out_reg.sv
// Result register holding one request until the downstream side takes it.
module lpfd_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  lpfd_pkg::result_t    res,
  input  logic                 out_stall,
  output logic                 out_valid,
  output lpfd_pkg::result_t    held
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

endmodule

### rtl/length_prefixed_frame_deframer_unit.sv
// Top level: input register, frame parser, result register, max_payload register.
// An accepted byte goes to the input register, then its result to the result register.
// Throughput: one byte per cycle unless stalled; the parser state update is the loop.
// The input stalls only while the registered byte's result waits behind a stalled result.
// Reset (rst, synchronous): both stages empty, header phase, max_payload = 10485760.
module length_prefixed_frame_deframer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] service_id,
  output logic [31:0] frame_length,
  output logic [7:0]  payload_byte,
  output logic        has_byte,
  output logic        last,
  output logic        status
);

  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic [31:0]       max_payload;
  logic              res_valid;
  logic              go;
  lpfd_pkg::result_t res;
  lpfd_pkg::result_t held;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= lpfd_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_payload <= cfg_data;
    end
  end

  // a byte with no result never waits on the output side
  assign go       = s1_valid && !(res_valid && out_valid && out_stall);
  assign in_stall = s1_valid && !go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= data_byte;
    end
  end

  lpfd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (go),
    .data_byte   (s1_byte),
    .max_payload (max_payload),
    .res_valid   (res_valid),
    .res         (res)
  );

  lpfd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (go && res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .held      (held)
  );

  assign service_id   = held.service_id;
  assign frame_length = held.frame_length;
  assign payload_byte = held.payload_byte;
  assign has_byte     = held.has_byte;
  assign last         = held.last;
  assign status       = held.status;

endmodule

### rtl/lpfd_checker.sv
// Port-level checks for the deframer, bound to the top level.
module lpfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] frame_length,
  input logic [7:0]  payload_byte,
  input logic        has_byte,
  input logic        last,
  input logic        status
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(payload_byte) && $stable(frame_length))
    else $error("stalled result changed");

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> !has_byte && !last && payload_byte == 8'd0)
    else $error("error request carries data");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_byte && !status |-> last && payload_byte == 8'd0 && frame_length == 32'd0)
    else $error("empty request malformed");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && status && !out_stall |=> !out_valid)
    else $error("request after length error");

endmodule

bind length_prefixed_frame_deframer_unit lpfd_checker u_checker (.*);
